/* rtl/core/hsr_pkg.sv */
// Shared types and constants of the hash slot rebalancer.
// Holds field widths, result codes, micro-op and jump codes, and the control store.
package hsr_pkg;

    localparam int ACT_W = 2;
    localparam int SID_W = 4;
    localparam int IDX_W = 10;
    localparam int ST_W  = 2;
    localparam int OWN_W = 4;
    localparam int CNT_W = 4;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [4:0] {
        U_NONE,
        U_ACCEPT,
        U_RES_ZERO,
        U_RD_ADDR,
        U_RD_DATA,
        U_ADD_CHK,
        U_MUL_ADD,
        U_MUL_REM,
        U_DIV_START,
        U_SET_QUOTA,
        U_SET_SHARE,
        U_SCAN_STEAL,
        U_SCAN_FILL,
        U_SCAN_GIVE,
        U_SCAN_CLEAR,
        U_COMMIT_ADD,
        U_REM_CHK,
        U_COMMIT_REM,
        U_POST
    } t_uop;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ACC,
        C_ACT_ADD,
        C_ACT_REM,
        C_ACT_RD,
        C_FULL,
        C_CNT_ZERO,
        C_CNT_ONE,
        C_BAD_ID,
        C_DIV_BUSY,
        C_SCAN_MORE,
        C_OUT_FREE
    } t_cond;

    typedef logic [4:0] t_step;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic acc;
        logic act_add;
        logic act_rem;
        logic act_rd;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic bad_id;
        logic div_busy;
        logic scan_more;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OWN_W-1:0] owner;
        logic [CNT_W-1:0] count;
    } t_res;

    localparam t_step P_IDLE       = 5'd0;
    localparam t_step P_DEC_ADD    = 5'd1;
    localparam t_step P_DEC_REM    = 5'd2;
    localparam t_step P_DEC_RD     = 5'd3;
    localparam t_step P_NOP_ACT    = 5'd4;
    localparam t_step P_RD_ADDR    = 5'd5;
    localparam t_step P_RD_DATA    = 5'd6;
    localparam t_step P_ADD_CHK    = 5'd7;
    localparam t_step P_ADD_FIRST  = 5'd8;
    localparam t_step P_ADD_MUL    = 5'd9;
    localparam t_step P_ADD_DIV    = 5'd10;
    localparam t_step P_ADD_WAIT   = 5'd11;
    localparam t_step P_ADD_QUOTA  = 5'd12;
    localparam t_step P_ADD_STEAL  = 5'd13;
    localparam t_step P_ADD_DRAIN  = 5'd14;
    localparam t_step P_ADD_FILL   = 5'd15;
    localparam t_step P_ADD_COMMIT = 5'd16;
    localparam t_step P_REM_CHK    = 5'd17;
    localparam t_step P_REM_LAST   = 5'd18;
    localparam t_step P_REM_MUL    = 5'd19;
    localparam t_step P_REM_DIV    = 5'd20;
    localparam t_step P_REM_WAIT   = 5'd21;
    localparam t_step P_REM_SHARE  = 5'd22;
    localparam t_step P_REM_GIVE   = 5'd23;
    localparam t_step P_REM_DRAIN  = 5'd24;
    localparam t_step P_REM_CLEAR  = 5'd25;
    localparam t_step P_REM_COMMIT = 5'd26;
    localparam t_step P_POST       = 5'd27;
    localparam t_step P_POST_WAIT  = 5'd28;
    localparam t_step P_BOOT       = 5'd29;
    localparam t_step P_BOOT_DRAIN = 5'd30;

    function automatic t_ctrl cw(input t_uop u, input t_cond c, input t_step t);
        t_ctrl w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        case (step)
            P_IDLE:       w = cw(U_ACCEPT,     C_NO_ACC,    P_IDLE);
            P_DEC_ADD:    w = cw(U_NONE,       C_ACT_ADD,   P_ADD_CHK);
            P_DEC_REM:    w = cw(U_NONE,       C_ACT_REM,   P_REM_CHK);
            P_DEC_RD:     w = cw(U_NONE,       C_ACT_RD,    P_RD_ADDR);
            P_NOP_ACT:    w = cw(U_RES_ZERO,   C_ALWAYS,    P_POST);
            P_RD_ADDR:    w = cw(U_RD_ADDR,    C_NEXT,      P_IDLE);
            P_RD_DATA:    w = cw(U_RD_DATA,    C_ALWAYS,    P_POST);
            P_ADD_CHK:    w = cw(U_ADD_CHK,    C_FULL,      P_POST);
            P_ADD_FIRST:  w = cw(U_NONE,       C_CNT_ZERO,  P_ADD_FILL);
            P_ADD_MUL:    w = cw(U_MUL_ADD,    C_NEXT,      P_IDLE);
            P_ADD_DIV:    w = cw(U_DIV_START,  C_NEXT,      P_IDLE);
            P_ADD_WAIT:   w = cw(U_NONE,       C_DIV_BUSY,  P_ADD_WAIT);
            P_ADD_QUOTA:  w = cw(U_SET_QUOTA,  C_NEXT,      P_IDLE);
            P_ADD_STEAL:  w = cw(U_SCAN_STEAL, C_SCAN_MORE, P_ADD_STEAL);
            P_ADD_DRAIN:  w = cw(U_NONE,       C_ALWAYS,    P_ADD_COMMIT);
            P_ADD_FILL:   w = cw(U_SCAN_FILL,  C_SCAN_MORE, P_ADD_FILL);
            P_ADD_COMMIT: w = cw(U_COMMIT_ADD, C_ALWAYS,    P_POST);
            P_REM_CHK:    w = cw(U_REM_CHK,    C_BAD_ID,    P_POST);
            P_REM_LAST:   w = cw(U_NONE,       C_CNT_ONE,   P_REM_CLEAR);
            P_REM_MUL:    w = cw(U_MUL_REM,    C_NEXT,      P_IDLE);
            P_REM_DIV:    w = cw(U_DIV_START,  C_NEXT,      P_IDLE);
            P_REM_WAIT:   w = cw(U_NONE,       C_DIV_BUSY,  P_REM_WAIT);
            P_REM_SHARE:  w = cw(U_SET_SHARE,  C_NEXT,      P_IDLE);
            P_REM_GIVE:   w = cw(U_SCAN_GIVE,  C_SCAN_MORE, P_REM_GIVE);
            P_REM_DRAIN:  w = cw(U_NONE,       C_ALWAYS,    P_REM_COMMIT);
            P_REM_CLEAR:  w = cw(U_SCAN_CLEAR, C_SCAN_MORE, P_REM_CLEAR);
            P_REM_COMMIT: w = cw(U_COMMIT_REM, C_ALWAYS,    P_POST);
            P_POST:       w = cw(U_POST,       C_OUT_FREE,  P_IDLE);
            P_POST_WAIT:  w = cw(U_NONE,       C_ALWAYS,    P_POST);
            P_BOOT:       w = cw(U_SCAN_CLEAR, C_SCAN_MORE, P_BOOT);
            P_BOOT_DRAIN: w = cw(U_NONE,       C_ALWAYS,    P_IDLE);
            default:      w = cw(U_NONE,       C_ALWAYS,    P_IDLE);
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/hash_slot_rebalancer.sv */
// Top level of the hash slot rebalancer: input and output registers around the
// micro-sequencer (hsr_seq) and the datapath (hsr_dp); types from hsr_pkg.
//
// Input channel (i_in_valid / o_in_stall) carries action, server id and slot
// index; output channel (o_out_valid / i_out_stall) returns status, owner id
// and server count, exactly one result per transfer. One item is worked on at
// a time; o_in_stall is low only while the sequencer sits at its idle step,
// which it reaches in the same cycle as a result is registered.
// Add and remove step once through the slot table, one slot per cycle on the
// table's single read and single write port, after a bit-serial quota
// division; the first add and the last remove skip the division. A full add,
// an unknown remove or an unused action answers without division or scan.
// After reset the table is cleared one slot per cycle while o_in_stall stays
// high. A result waits in the output register while i_out_stall is high;
// the next item may be taken meanwhile, and its result holds in the datapath
// until the output register frees.
module hash_slot_rebalancer #(
    parameter int SLOTS       = 1024,
    parameter int MAX_SERVERS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [hsr_pkg::ACT_W-1:0] i_action,
    input  logic [hsr_pkg::SID_W-1:0] i_server_id,
    input  logic [hsr_pkg::IDX_W-1:0] i_slot_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [hsr_pkg::ST_W-1:0]  o_status,
    output logic [hsr_pkg::OWN_W-1:0] o_owner_id,
    output logic [hsr_pkg::CNT_W-1:0] o_server_count
);
    import hsr_pkg::*;

    t_uop             w_uop;
    t_flags           w_flags;
    t_res             w_res;
    logic             w_acc;
    logic             w_out_free;
    logic [ACT_W-1:0] r_action;
    logic [SID_W-1:0] r_sid;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_res             r_res;

    assign o_in_stall = (w_uop != U_ACCEPT);
    assign w_acc      = i_in_valid && (w_uop == U_ACCEPT);
    assign w_out_free = !r_out_valid || !i_out_stall;

    hsr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uop   (w_uop)
    );

    hsr_dp #(
        .SLOTS       (SLOTS),
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (w_uop),
        .i_action   (r_action),
        .i_sid      (r_sid),
        .i_idx      (r_idx),
        .i_acc      (w_acc),
        .i_out_free (w_out_free),
        .o_flags    (w_flags),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_action <= i_action;
            r_sid    <= i_server_id;
            r_idx    <= i_slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_uop == U_POST) && w_out_free) begin
            r_out_valid <= 1'b1;
            r_res       <= w_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_res.status;
    assign o_owner_id     = r_res.owner;
    assign o_server_count = r_res.count;

endmodule

/* rtl/core/hsr_div.sv */
// Restoring divider of a fixed dividend by the divisor on i_den, one bit per cycle.
// Depends on nothing outside this file.
module hsr_div #(
    parameter int DVD   = 1024,
    parameter int DVD_W = 11,
    parameter int DEN_W = 8,
    parameter int Q_W   = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_quo
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DVD_W-1:0] r_q;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DVD_W);
            r_rem  <= '0;
            r_q    <= DVD_W'(DVD);
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_q    <= {r_q[DVD_W-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = Q_W'(r_q);

endmodule

/* rtl/core/hsr_dp.sv */
// Datapath of the rebalancer: slot table, server set, quotas, receiver pointer.
// Uses hsr_pkg for micro-op codes and hsr_div for the quota division.
module hsr_dp #(
    parameter int SLOTS       = 1024,
    parameter int MAX_SERVERS = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hsr_pkg::t_uop               i_uop,
    input  logic [hsr_pkg::ACT_W-1:0]   i_action,
    input  logic [hsr_pkg::SID_W-1:0]   i_sid,
    input  logic [hsr_pkg::IDX_W-1:0]   i_idx,
    input  logic                        i_acc,
    input  logic                        i_out_free,
    output hsr_pkg::t_flags             o_flags,
    output hsr_pkg::t_res               o_res
);
    import hsr_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ID_W   = $clog2(MAX_SERVERS + 1);
    localparam int DEN_W  = 2 * ID_W;
    localparam int DVD_W  = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {M_CLEAR, M_FILL, M_STEAL, M_GIVE} t_mode;

    logic [ID_W-1:0]   r_mem [0:SLOTS-1];
    logic [ID_W-1:0]   r_rd;
    logic [SLOT_W-1:0] r_j;
    logic [SLOT_W-1:0] r_jd;
    logic              r_dv;
    t_mode             r_mode;
    logic [ID_W-1:0]   r_tid;
    logic [ID_W-1:0]   r_owner;
    logic [ID_W-1:0]   r_count;
    logic [ID_W-1:0]   r_recv;
    logic [ST_W-1:0]   r_status;
    logic [MAX_SERVERS:0] r_present;
    logic [SLOT_W-1:0] r_quota [0:MAX_SERVERS];
    logic [SLOT_W-1:0] r_share;
    logic [SLOT_W-1:0] r_used;
    logic [DEN_W-1:0]  r_den;

    logic [SLOT_W-1:0] w_ra;
    logic              w_we;
    logic [ID_W-1:0]   w_wd;
    logic              w_scan;
    t_mode             w_mode;
    logic              w_steal;
    logic              w_give;
    logic              w_full;
    logic              w_bad;
    logic              w_idx_ok;
    logic [ID_W-1:0]   w_sid;
    logic [ID_W-1:0]   w_free;
    logic [ID_W-1:0]   w_adj;
    logic [MAX_SERVERS:0] w_mask;
    logic [ID_W-1:0]   w_first_rcv;
    logic [ID_W-1:0]   w_next_rcv;
    logic              w_div_busy;
    logic [SLOT_W-1:0] w_quo;

    function automatic logic [ID_W-1:0] next_rcv(input logic [MAX_SERVERS:0] mask,
                                                  input logic [ID_W-1:0] cur);
        logic [ID_W-1:0] first;
        logic [ID_W-1:0] after;
        first = '0;
        after = '0;
        for (int k = MAX_SERVERS; k >= 1; k--) begin
            if (mask[k]) begin
                first = ID_W'(k);
                if (ID_W'(k) > cur) begin
                    after = ID_W'(k);
                end
            end
        end
        return (after != '0) ? after : first;
    endfunction

    hsr_div #(
        .DVD   (SLOTS),
        .DVD_W (DVD_W),
        .DEN_W (DEN_W),
        .Q_W   (SLOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_uop == U_DIV_START),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_free = '0;
        for (int k = MAX_SERVERS; k >= 1; k--) begin
            if (!r_present[k]) begin
                w_free = ID_W'(k);
            end
        end
        w_mask        = r_present;
        w_mask[r_tid] = 1'b0;
    end

    assign w_first_rcv = next_rcv(w_mask, '0);
    assign w_next_rcv  = next_rcv(w_mask, r_recv);

    assign w_sid    = ID_W'(i_sid);
    assign w_bad    = !((i_sid != '0) && (int'(i_sid) <= MAX_SERVERS) && r_present[w_sid]);
    assign w_idx_ok = int'(i_idx) < SLOTS;
    assign w_full   = r_count >= ID_W'(MAX_SERVERS);
    assign w_adj    = (i_uop == U_MUL_ADD) ? r_count + 1'b1 : r_count - 1'b1;
    assign w_ra     = (i_uop == U_RD_ADDR) ? SLOT_W'(i_idx) : r_j;

    assign w_steal = (r_rd != '0) && (int'(r_rd) <= MAX_SERVERS) && (r_quota[r_rd] != '0);
    assign w_give  = (r_rd == r_tid);

    always_comb begin
        w_scan = 1'b1;
        w_mode = M_CLEAR;
        case (i_uop)
            U_SCAN_CLEAR: w_mode = M_CLEAR;
            U_SCAN_FILL:  w_mode = M_FILL;
            U_SCAN_STEAL: w_mode = M_STEAL;
            U_SCAN_GIVE:  w_mode = M_GIVE;
            default:      w_scan = 1'b0;
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_wd = '0;
        case (r_mode)
            M_CLEAR: begin
                w_we = r_dv;
                w_wd = '0;
            end
            M_FILL: begin
                w_we = r_dv;
                w_wd = r_tid;
            end
            M_STEAL: begin
                w_we = r_dv && w_steal;
                w_wd = r_tid;
            end
            M_GIVE: begin
                w_we = r_dv && w_give;
                w_wd = r_recv;
            end
            default: begin
                w_we = 1'b0;
                w_wd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_jd] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j       <= '0;
            r_dv      <= 1'b0;
            r_mode    <= M_CLEAR;
            r_count   <= '0;
            r_present <= '0;
        end else begin
            r_dv <= w_scan;
            r_jd <= r_j;
            if (w_scan) begin
                r_mode <= w_mode;
                r_j    <= (r_j == SLOT_W'(SLOTS - 1)) ? '0 : r_j + 1'b1;
            end
            if (r_dv && (r_mode == M_STEAL) && w_steal) begin
                r_quota[r_rd] <= r_quota[r_rd] - 1'b1;
            end
            if (r_dv && (r_mode == M_GIVE) && w_give) begin
                if (SLOT_W'(r_used + 1'b1) == r_share) begin
                    r_used <= '0;
                    r_recv <= w_next_rcv;
                end else begin
                    r_used <= r_used + 1'b1;
                end
            end
            case (i_uop)
                U_RES_ZERO: begin
                    r_status <= ST_OK;
                    r_owner  <= '0;
                end
                U_RD_DATA: begin
                    r_status <= ST_OK;
                    r_owner  <= w_idx_ok ? r_rd : '0;
                end
                U_ADD_CHK: begin
                    if (w_full) begin
                        r_status <= ST_FULL;
                        r_owner  <= '0;
                    end else begin
                        r_status <= ST_OK;
                        r_owner  <= w_free;
                        r_tid    <= w_free;
                    end
                end
                U_REM_CHK: begin
                    r_status <= w_bad ? ST_UNKNOWN : ST_OK;
                    r_owner  <= '0;
                    r_tid    <= w_sid;
                end
                U_MUL_ADD: begin
                    r_den <= DEN_W'(r_count) * DEN_W'(w_adj);
                end
                U_MUL_REM: begin
                    r_den  <= DEN_W'(r_count) * DEN_W'(w_adj);
                    r_recv <= w_first_rcv;
                    r_used <= '0;
                end
                U_SET_QUOTA: begin
                    for (int k = 0; k <= MAX_SERVERS; k++) begin
                        r_quota[k] <= r_present[k] ? w_quo : '0;
                    end
                end
                U_SET_SHARE: begin
                    r_share <= (w_quo == '0) ? SLOT_W'(1) : w_quo;
                end
                U_COMMIT_ADD: begin
                    r_present[r_tid] <= 1'b1;
                    r_count          <= r_count + 1'b1;
                end
                U_COMMIT_REM: begin
                    r_present[r_tid] <= 1'b0;
                    r_count          <= r_count - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_flags.acc       = i_acc;
        o_flags.act_add   = (i_action == ACT_ADD);
        o_flags.act_rem   = (i_action == ACT_REMOVE);
        o_flags.act_rd    = (i_action == ACT_READ);
        o_flags.full      = w_full;
        o_flags.cnt_zero  = (r_count == '0);
        o_flags.cnt_one   = (r_count == ID_W'(1));
        o_flags.bad_id    = w_bad;
        o_flags.div_busy  = w_div_busy;
        o_flags.scan_more = (r_j != SLOT_W'(SLOTS - 1));
        o_flags.out_free  = i_out_free;
    end

    assign o_res.status = r_status;
    assign o_res.owner  = OWN_W'(r_owner);
    assign o_res.count  = CNT_W'(r_count);

endmodule

/* rtl/core/hsr_seq.sv */
// Micro-sequencer: step counter over the control store with conditional jumps.
// Uses hsr_pkg for the control store and the jump codes.
module hsr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hsr_pkg::t_flags i_flags,
    output hsr_pkg::t_uop   o_uop
);
    import hsr_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_take;

    assign w_ctrl = ucode(r_step);

    always_comb begin
        case (w_ctrl.cond)
            C_NEXT:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_ACC:    w_take = !i_flags.acc;
            C_ACT_ADD:   w_take = i_flags.act_add;
            C_ACT_REM:   w_take = i_flags.act_rem;
            C_ACT_RD:    w_take = i_flags.act_rd;
            C_FULL:      w_take = i_flags.full;
            C_CNT_ZERO:  w_take = i_flags.cnt_zero;
            C_CNT_ONE:   w_take = i_flags.cnt_one;
            C_BAD_ID:    w_take = i_flags.bad_id;
            C_DIV_BUSY:  w_take = i_flags.div_busy;
            C_SCAN_MORE: w_take = i_flags.scan_more;
            C_OUT_FREE:  w_take = i_flags.out_free;
            default:     w_take = 1'b0;
        endcase
        n_step = w_take ? w_ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= P_BOOT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uop = w_ctrl.uop;

endmodule

/* rtl/core/hsr_chk.sv */
// Port-level checker for the hash slot rebalancer, bound to the top level.
// Uses hsr_pkg for status codes and field widths.
module hsr_chk #(
    parameter int MAX_SERVERS = 15
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [hsr_pkg::ST_W-1:0]  o_status,
    input logic [hsr_pkg::OWN_W-1:0] o_owner_id,
    input logic [hsr_pkg::CNT_W-1:0] o_server_count
);
    import hsr_pkg::*;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on two adjacent cycles");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |->
            ((o_owner_id == '0) && (o_server_count == CNT_W'(MAX_SERVERS))))
        else $error("full status with owner or wrong count");

    a_unknown_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNKNOWN)) |-> (o_owner_id == '0))
        else $error("unknown server status with an owner id");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_owner_id)
             && $stable(o_server_count)))
        else $error("stalled result changed");

endmodule

bind hash_slot_rebalancer hsr_chk #(
    .MAX_SERVERS (MAX_SERVERS)
) u_hsr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_owner_id     (o_owner_id),
    .o_server_count (o_server_count)
);
